/* hdl/vertices_reachable_from_all_defines.svh */
// ---------------------------------------------------------------------------
// vertices_reachable_from_all_defines.svh
// Assertion macros shared by the reachability block.
// ---------------------------------------------------------------------------
`ifndef VERTICES_REACHABLE_FROM_ALL_DEFINES_SVH
`define VERTICES_REACHABLE_FROM_ALL_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check that cons holds in the same cycle as ante
`define VRFA_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vrfa assertion failed");

// Check that cons holds in the cycle after ante
`define VRFA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vrfa assertion failed");

`else

`define VRFA_ASSERT_NOW(name, clk, rst, ante, cons)

`define VRFA_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

/* hdl/vrfa_pkg.sv */
// ---------------------------------------------------------------------------
// vrfa_pkg
// Types and constants of the all-sources reachability block.
// ---------------------------------------------------------------------------
package vrfa_pkg;

   // Field widths of the request, response and register channels
   localparam int COUNT_W  = 7;
   localparam int EDGE_W   = 6;
   localparam int ANSWER_W = 64;

   // Default vertex capacity and register reset value
   localparam int             MAX_VERTICES_DEF = 64;
   localparam logic [COUNT_W-1:0] COUNT_RESET  = 7'd64;

   // Request kinds
   localparam logic KIND_EDGE    = 1'b0;
   localparam logic KIND_COMPUTE = 1'b1;

   // Closure sequencer states
   typedef enum logic [2:0] {
      CLO_IDLE,
      CLO_INIT,
      CLO_KROW,
      CLO_SWEEP,
      CLO_ANS,
      CLO_FINISH
   } clo_state_type;

   // Operation carried by the memory read stage
   typedef enum logic [2:0] {
      OP_NONE,
      OP_INIT,
      OP_KROW,
      OP_UPD,
      OP_ANS
   } pipe_op_type;

   // Closure commands to the adjacency store
   typedef struct packed {
      logic rd_en;
      logic clear;
   } adj_cmd_type;

   // Closure status toward the top level
   typedef struct packed {
      logic idle;
      logic res_vld;
   } clo_stat_type;

endpackage

/* hdl/vrfa_channels.sv */
// ---------------------------------------------------------------------------
// vrfa_channels
// Valid/ready channel interfaces for requests, responses and the register.
// ---------------------------------------------------------------------------

// Request channel: edge load or compute
interface vrfa_req_if;
   logic                           valid;
   logic                           ready;
   logic                           kind;
   logic [vrfa_pkg::EDGE_W-1:0]    edge_from;
   logic [vrfa_pkg::EDGE_W-1:0]    edge_to;

   modport source (output valid, kind, edge_from, edge_to, input ready);
   modport sink   (input valid, kind, edge_from, edge_to, output ready);
endinterface

// Response channel: answer mask
interface vrfa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [vrfa_pkg::ANSWER_W-1:0]  answer_mask;

   modport source (output valid, answer_mask, input ready);
   modport sink   (input valid, answer_mask, output ready);
endinterface

// Register write channel: vertex count
interface vrfa_csr_if;
   logic                           valid;
   logic                           ready;
   logic [vrfa_pkg::COUNT_W-1:0]   vertex_count;

   modport source (output valid, vertex_count, input ready);
   modport sink   (input valid, vertex_count, output ready);
endinterface

/* hdl/vertices_reachable_from_all.sv */
// ---------------------------------------------------------------------------
// vertices_reachable_from_all
// Vertices reachable from every vertex of a directed graph.
// ---------------------------------------------------------------------------
// Use: write vertex_count on the csr channel while the block is idle. Send
// edge requests (kind 0) on the req channel, one per cycle; each sets one
// bit of the adjacency store and produces no response. A compute request
// (kind 1) runs the reflexive transitive closure over the vertices in use
// and returns one answer_mask on the rsp channel, then clears the graph.
// Timing: edge requests go through a two-stage read-modify-write of the
// adjacency memory at one per cycle while idle. A compute request of n
// vertices holds req ready low until its answer is handed over: one
// reach-memory row a cycle over n pivot sweeps, each led by a pivot row
// read, plus the row copy and the AND pass, all skipped when n is zero.
// Reset: the graph is empty and vertex_count is 64; no memory sweep runs.
// Stall: the answer waits in the rsp output register; edge requests are
// still taken meanwhile, and a later answer waits in the sequencer.
// ---------------------------------------------------------------------------
`include "vertices_reachable_from_all_defines.svh"

module vertices_reachable_from_all #(
   parameter int MAX_VERTICES = vrfa_pkg::MAX_VERTICES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   vrfa_req_if.sink   req_bus,
   vrfa_rsp_if.source rsp_bus,
   vrfa_csr_if.sink   csr_bus
);

   localparam int W     = MAX_VERTICES;
   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CW    = vrfa_pkg::COUNT_W;

   logic [CW-1:0]                   count_ff;
   logic                            rsp_valid_ff;
   logic [vrfa_pkg::ANSWER_W-1:0]   rsp_mask_ff;

   logic                            req_take;
   logic                            start;
   logic                            load_vld;
   logic                            res_free;
   vrfa_pkg::adj_cmd_type           adj_cmd;
   vrfa_pkg::clo_stat_type          stat;
   logic [IDX_W-1:0]                adj_addr;
   logic [W-1:0]                    adj_rd_data;
   logic [W-1:0]                    res_mask;

   // Decode accepted requests, drop edges outside the store
   assign req_bus.ready = stat.idle;
   assign req_take      = req_bus.valid & req_bus.ready;
   assign start         = req_take && (req_bus.kind == vrfa_pkg::KIND_COMPUTE);
   assign load_vld      = req_take && (req_bus.kind == vrfa_pkg::KIND_EDGE)
                          && (CW'(req_bus.edge_from) < CW'(MAX_VERTICES))
                          && (CW'(req_bus.edge_to) < CW'(MAX_VERTICES));

   assign csr_bus.ready = 1'b1;
   assign res_free      = !rsp_valid_ff || rsp_bus.ready;

   vrfa_adj_store #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_adj_store (
      .clock    (clock),
      .reset    (reset),
      .load_vld (load_vld),
      .load_row (req_bus.edge_from[IDX_W-1:0]),
      .load_col (req_bus.edge_to[IDX_W-1:0]),
      .cmd      (adj_cmd),
      .clo_addr (adj_addr),
      .rd_data  (adj_rd_data)
   );

   vrfa_closure #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_closure (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .count       (count_ff),
      .adj_rd_data (adj_rd_data),
      .res_free    (res_free),
      .adj_cmd     (adj_cmd),
      .adj_addr    (adj_addr),
      .stat        (stat),
      .res_mask    (res_mask)
   );

   // Vertex count register and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= vrfa_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_bus.valid) begin
            count_ff <= csr_bus.vertex_count;
         end
         if (stat.res_vld) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the answer until taken
   always_ff @(posedge clock) begin
      if (stat.res_vld) begin
         rsp_mask_ff <= vrfa_pkg::ANSWER_W'(res_mask);
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.answer_mask = rsp_mask_ff;

   // A compute request takes the sequencer out of idle
   `VRFA_ASSERT_NEXT(a_start_busy, clock, reset, start, !stat.idle)
   // An answer is only handed over into a free response slot
   `VRFA_ASSERT_NOW(a_res_free, clock, reset, stat.res_vld, res_free)
   // Edge loads never share the adjacency read port with the closure
   `VRFA_ASSERT_NOW(a_port_share, clock, reset, load_vld, !adj_cmd.rd_en)
   // A handed-over answer shows up on the response channel next cycle
   `VRFA_ASSERT_NEXT(a_res_out, clock, reset, stat.res_vld, rsp_bus.valid)

endmodule

/* hdl/vrfa_ram.sv */
// ---------------------------------------------------------------------------
// vrfa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module vrfa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, and read old data on a same-address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/vrfa_adj_store.sv */
// ---------------------------------------------------------------------------
// vrfa_adj_store
// Adjacency bit store: one row per source vertex, read-modify-write edge
// loads at one per cycle, row valid bits that clear every row at once.
// ---------------------------------------------------------------------------
module vrfa_adj_store #(
   parameter int MAX_VERTICES = vrfa_pkg::MAX_VERTICES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load_vld,
   input  logic [$clog2(MAX_VERTICES)-1:0] load_row,
   input  logic [$clog2(MAX_VERTICES)-1:0] load_col,
   input  vrfa_pkg::adj_cmd_type           cmd,
   input  logic [$clog2(MAX_VERTICES)-1:0] clo_addr,
   output logic [MAX_VERTICES-1:0]         rd_data
);

   localparam int W     = MAX_VERTICES;
   localparam int IDX_W = $clog2(MAX_VERTICES);

   logic [W-1:0]     row_valid_ff;
   logic             s1_vld_ff;
   logic [IDX_W-1:0] s1_row_ff;
   logic [IDX_W-1:0] s1_col_ff;
   logic [IDX_W-1:0] rd_row_ff;
   logic             wr_vld_ff;
   logic [IDX_W-1:0] wr_row_ff;
   logic [W-1:0]     wr_data_ff;

   logic             ram_rd_en;
   logic [IDX_W-1:0] ram_rd_addr;
   logic [W-1:0]     ram_rd_data;
   logic             fwd_hit;
   logic [W-1:0]     row_data;
   logic [W-1:0]     wr_data_in;

   // Share the read port between edge loads and the closure
   assign ram_rd_en   = load_vld | cmd.rd_en;
   assign ram_rd_addr = load_vld ? load_row : clo_addr;

   // Forward the row written last cycle, drop rows not written since clear
   assign fwd_hit  = wr_vld_ff && (wr_row_ff == rd_row_ff);
   assign row_data = !row_valid_ff[rd_row_ff] ? '0 :
                     fwd_hit ? wr_data_ff : ram_rd_data;
   assign rd_data  = row_data;

   // Merge the new edge into its row
   assign wr_data_in = row_data | (W'(1) << s1_col_ff);

   vrfa_ram #(
      .WIDTH (W),
      .DEPTH (MAX_VERTICES)
   ) u_adj_ram (
      .clock   (clock),
      .wr_en   (s1_vld_ff),
      .wr_addr (s1_row_ff),
      .wr_data (wr_data_in),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Track the load stage and the last write
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         wr_vld_ff    <= 1'b0;
         row_valid_ff <= '0;
      end else begin
         s1_vld_ff <= load_vld;
         wr_vld_ff <= s1_vld_ff;
         if (cmd.clear) begin
            row_valid_ff <= '0;
         end else if (s1_vld_ff) begin
            row_valid_ff[s1_row_ff] <= 1'b1;
         end
      end
   end

   // Hold payload of the load stage and the forward register
   always_ff @(posedge clock) begin
      s1_row_ff  <= load_row;
      s1_col_ff  <= load_col;
      rd_row_ff  <= ram_rd_addr;
      wr_row_ff  <= s1_row_ff;
      wr_data_ff <= wr_data_in;
   end

endmodule

/* hdl/vrfa_closure.sv */
// ---------------------------------------------------------------------------
// vrfa_closure
// Closure sequencer: copies adjacency rows into the reach memory, runs the
// pivot sweeps over it, then ANDs all rows into the answer mask.
// ---------------------------------------------------------------------------
module vrfa_closure #(
   parameter int MAX_VERTICES = vrfa_pkg::MAX_VERTICES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [vrfa_pkg::COUNT_W-1:0]    count,
   input  logic [MAX_VERTICES-1:0]         adj_rd_data,
   input  logic                            res_free,
   output vrfa_pkg::adj_cmd_type           adj_cmd,
   output logic [$clog2(MAX_VERTICES)-1:0] adj_addr,
   output vrfa_pkg::clo_stat_type          stat,
   output logic [MAX_VERTICES-1:0]         res_mask
);

   localparam int W     = MAX_VERTICES;
   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CW    = vrfa_pkg::COUNT_W;

   vrfa_pkg::clo_state_type state_ff, state_in;
   vrfa_pkg::pipe_op_type   p_op_ff, rd_op;
   logic [IDX_W-1:0]        i_ff, i_in;
   logic [IDX_W-1:0]        k_ff, k_in;
   logic [IDX_W-1:0]        last_ff;
   logic [IDX_W-1:0]        p_idx_ff;
   logic [IDX_W-1:0]        p_k_ff;
   logic [IDX_W-1:0]        rd_idx;
   logic [W-1:0]            act_ff;
   logic [W-1:0]            ans_ff;
   logic [W-1:0]            rk_ff;

   logic [CW-1:0]           n_sat;
   logic                    n_zero;
   logic [W-1:0]            act_in;
   logic                    wr_pending;
   logic                    reach_rd_en;
   logic [W-1:0]            reach_rd_data;
   logic                    reach_wr_en;
   logic [W-1:0]            reach_wr_data;

   // Saturate the vertex count and build the in-use mask
   assign n_sat  = (count > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : count;
   assign n_zero = (count == '0);
   always_comb begin
      for (int v = 0; v < W; v++) begin
         act_in[v] = (CW'(v) < n_sat);
      end
   end

   assign wr_pending = (p_op_ff == vrfa_pkg::OP_INIT) || (p_op_ff == vrfa_pkg::OP_UPD);

   // Next state and read issue
   always_comb begin
      state_in       = state_ff;
      i_in           = i_ff;
      k_in           = k_ff;
      rd_op          = vrfa_pkg::OP_NONE;
      rd_idx         = i_ff;
      adj_cmd.rd_en  = 1'b0;
      adj_cmd.clear  = 1'b0;
      reach_rd_en    = 1'b0;
      stat.idle      = 1'b0;
      stat.res_vld   = 1'b0;
      unique case (state_ff)
         vrfa_pkg::CLO_IDLE: begin
            stat.idle = 1'b1;
            if (start) begin
               i_in     = '0;
               state_in = n_zero ? vrfa_pkg::CLO_FINISH : vrfa_pkg::CLO_INIT;
            end
         end
         vrfa_pkg::CLO_INIT: begin
            rd_op         = vrfa_pkg::OP_INIT;
            adj_cmd.rd_en = 1'b1;
            if (i_ff == last_ff) begin
               i_in     = '0;
               k_in     = '0;
               state_in = vrfa_pkg::CLO_KROW;
            end else begin
               i_in = IDX_W'(i_ff + 1'b1);
            end
         end
         vrfa_pkg::CLO_KROW: begin
            // Wait until the last row write has landed
            if (!wr_pending) begin
               rd_op       = vrfa_pkg::OP_KROW;
               rd_idx      = k_ff;
               reach_rd_en = 1'b1;
               i_in        = '0;
               state_in    = vrfa_pkg::CLO_SWEEP;
            end
         end
         vrfa_pkg::CLO_SWEEP: begin
            rd_op       = vrfa_pkg::OP_UPD;
            reach_rd_en = 1'b1;
            if (i_ff == last_ff) begin
               i_in = '0;
               if (k_ff == last_ff) begin
                  state_in = vrfa_pkg::CLO_ANS;
               end else begin
                  k_in     = IDX_W'(k_ff + 1'b1);
                  state_in = vrfa_pkg::CLO_KROW;
               end
            end else begin
               i_in = IDX_W'(i_ff + 1'b1);
            end
         end
         vrfa_pkg::CLO_ANS: begin
            if (!wr_pending) begin
               rd_op       = vrfa_pkg::OP_ANS;
               reach_rd_en = 1'b1;
               if (i_ff == last_ff) begin
                  state_in = vrfa_pkg::CLO_FINISH;
               end else begin
                  i_in = IDX_W'(i_ff + 1'b1);
               end
            end
         end
         vrfa_pkg::CLO_FINISH: begin
            // Hand over the answer once the last row is folded in
            if ((p_op_ff == vrfa_pkg::OP_NONE) && res_free) begin
               stat.res_vld  = 1'b1;
               adj_cmd.clear = 1'b1;
               state_in      = vrfa_pkg::CLO_IDLE;
            end
         end
         default: begin
            state_in = vrfa_pkg::CLO_IDLE;
         end
      endcase
   end

   assign adj_addr = rd_idx;
   assign res_mask = ans_ff;

   // Row update from the read stage
   always_comb begin
      reach_wr_en   = 1'b0;
      reach_wr_data = reach_rd_data | rk_ff;
      case (p_op_ff)
         vrfa_pkg::OP_INIT: begin
            reach_wr_en   = 1'b1;
            reach_wr_data = (adj_rd_data & act_ff) | (W'(1) << p_idx_ff);
         end
         vrfa_pkg::OP_UPD: begin
            reach_wr_en = reach_rd_data[p_k_ff];
         end
         default: begin
            reach_wr_en = 1'b0;
         end
      endcase
   end

   vrfa_ram #(
      .WIDTH (W),
      .DEPTH (MAX_VERTICES)
   ) u_reach_ram (
      .clock   (clock),
      .wr_en   (reach_wr_en),
      .wr_addr (p_idx_ff),
      .wr_data (reach_wr_data),
      .rd_en   (reach_rd_en),
      .rd_addr (rd_idx),
      .rd_data (reach_rd_data)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vrfa_pkg::CLO_IDLE;
         p_op_ff  <= vrfa_pkg::OP_NONE;
      end else begin
         state_ff <= state_in;
         p_op_ff  <= rd_op;
      end
   end

   // Counters, read stage tags and row accumulators
   always_ff @(posedge clock) begin
      i_ff     <= i_in;
      k_ff     <= k_in;
      p_idx_ff <= rd_idx;
      p_k_ff   <= k_ff;
      if (start && (state_ff == vrfa_pkg::CLO_IDLE)) begin
         last_ff <= IDX_W'(n_sat - 1'b1);
         act_ff  <= act_in;
         ans_ff  <= n_zero ? '0 : act_in;
      end else if (p_op_ff == vrfa_pkg::OP_ANS) begin
         ans_ff <= ans_ff & reach_rd_data;
      end
      if (p_op_ff == vrfa_pkg::OP_KROW) begin
         rk_ff <= reach_rd_data;
      end
   end

endmodule

/* sim/tb_vertices_reachable_from_all.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_vertices_reachable_from_all
// Self-checking bench for the all-sources reachability block.
// ---------------------------------------------------------------------------
// Edge loads and compute requests go out through a queue-fed driver. A
// bit-level model of the adjacency store forms the reflexive transitive
// closure on every accepted compute request and queues the answer mask,
// which is compared against each accepted response. Each test phase after
// the first writes a new vertex count while the block is idle. Both channels
// idle at random, and one directed phase and some random phases hold the
// response side off long enough to back up the request side.
// ---------------------------------------------------------------------------
module tb_vertices_reachable_from_all;

   localparam int MAX_V         = vrfa_pkg::MAX_VERTICES_DEF;
   localparam int RANDOM_ITEMS  = 500;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 600;
   localparam int CYCLE_LIMIT   = 2000000;

   typedef struct packed {
      logic                        kind;
      logic [vrfa_pkg::EDGE_W-1:0] src;
      logic [vrfa_pkg::EDGE_W-1:0] dst;
   } graph_req_type;

   logic clock;
   logic reset;

   vrfa_req_if req_bus ();
   vrfa_rsp_if rsp_bus ();
   vrfa_csr_if csr_bus ();

   vertices_reachable_from_all i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Model state
   logic [vrfa_pkg::ANSWER_W-1:0] adj_rows [MAX_V];
   logic [vrfa_pkg::COUNT_W-1:0]  model_count;
   logic [vrfa_pkg::ANSWER_W-1:0] answers_due [$];

   // Stimulus state
   graph_req_type pending_reqs [$];
   graph_req_type next_req;
   logic          req_fire = 1'b0;
   bit            no_gaps = 1'b0;
   int            send_gap = 0;
   int            rsp_gap = 0;
   int            hold_left = 0;
   int            hold_requests = 0;
   int            holds_done = 0;
   int            items_queued = 0;
   int            fail_count = 0;
   int            cycle_count = 0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Idle length: mostly none, some short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Reflexive transitive closure over the vertices in use, ANDed over rows
   function automatic logic [vrfa_pkg::ANSWER_W-1:0] reach_from_all(input int unsigned n);
      logic [vrfa_pkg::ANSWER_W-1:0] reach [MAX_V];
      logic [vrfa_pkg::ANSWER_W-1:0] act;
      logic [vrfa_pkg::ANSWER_W-1:0] mask;
      int                            i;
      int                            k;
      act  = (n >= vrfa_pkg::ANSWER_W) ? '1 : ((64'd1 << n) - 64'd1);
      mask = act;
      for (i = 0; i < n; i++) reach[i] = (adj_rows[i] & act) | (64'd1 << i);
      for (k = 0; k < n; k++) begin
         for (i = 0; i < n; i++) begin
            if (reach[i][k]) reach[i] = reach[i] | reach[k];
         end
      end
      for (i = 0; i < n; i++) mask = mask & reach[i];
      if (n == 0) mask = '0;
      return mask;
   endfunction

   // Drive requests from the pending queue, holding each until accepted
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fire) begin
         if (send_gap > 0) begin
            req_bus.valid <= 1'b0;
            send_gap--;
         end else if (pending_reqs.size() > 0) begin
            next_req = pending_reqs.pop_front();
            req_bus.valid     <= 1'b1;
            req_bus.kind      <= next_req.kind;
            req_bus.edge_from <= next_req.src;
            req_bus.edge_to   <= next_req.dst;
            send_gap = pick_gap();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response ready: random stalls, plus long hold-offs on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (hold_requests != holds_done) begin
            holds_done = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (rsp_gap > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_gap--;
         end else begin
            rsp_bus.ready <= 1'b1;
            rsp_gap = pick_gap();
         end
      end
   end

   // Check responses, then advance the model on accepted requests
   always @(posedge clock) begin
      logic [vrfa_pkg::ANSWER_W-1:0] want;
      int unsigned                   n;
      if (reset) begin
         req_fire <= 1'b0;
         model_count = vrfa_pkg::COUNT_RESET;
         foreach (adj_rows[i]) adj_rows[i] = '0;
      end else begin
         req_fire <= req_bus.valid && req_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (answers_due.size() == 0) begin
               $error("unexpected response: answer_mask %h", rsp_bus.answer_mask);
               fail_count++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_bus.answer_mask !== want) begin
                  $error("answer_mask: expected %h, actual %h", want, rsp_bus.answer_mask);
                  fail_count++;
               end
            end
         end
         if (csr_bus.valid && csr_bus.ready) model_count = csr_bus.vertex_count;
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.kind == vrfa_pkg::KIND_EDGE) begin
               adj_rows[req_bus.edge_from][req_bus.edge_to] = 1'b1;
            end else begin
               n = (model_count > MAX_V) ? MAX_V : model_count;
               answers_due.push_back(reach_from_all(n));
               foreach (adj_rows[i]) adj_rows[i] = '0;
            end
         end
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic add_edge(input int src, input int dst);
      graph_req_type r;
      r.kind = vrfa_pkg::KIND_EDGE;
      r.src  = src[vrfa_pkg::EDGE_W-1:0];
      r.dst  = dst[vrfa_pkg::EDGE_W-1:0];
      pending_reqs.push_back(r);
      items_queued++;
   endtask

   task automatic add_compute();
      graph_req_type r;
      r.kind = vrfa_pkg::KIND_COMPUTE;
      r.src  = vrfa_pkg::EDGE_W'($urandom_range(0, 63));
      r.dst  = vrfa_pkg::EDGE_W'($urandom_range(0, 63));
      pending_reqs.push_back(r);
      items_queued++;
   endtask

   // Wait until all requests are out and all answers are back, then settle
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_bus.valid || answers_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_count(input logic [vrfa_pkg::COUNT_W-1:0] value);
      @(negedge clock);
      csr_bus.valid        <= 1'b1;
      csr_bus.vertex_count <= value;
      do @(posedge clock);
      while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // One graph and its compute: mostly an in-tree toward a random sink with
   // a few links dropped, plus random extra links and some stray endpoints
   task automatic queue_graph(input int n);
      int order [$];
      int i;
      int j;
      int tmp;
      int extra;
      if (n >= 2 && $urandom_range(0, 3) != 0) begin
         for (i = 0; i < n; i++) order.push_back(i);
         for (i = n - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
         end
         for (i = 1; i < n; i++) begin
            if ($urandom_range(0, 9) != 0) add_edge(order[i], order[$urandom_range(0, i - 1)]);
         end
      end
      extra = $urandom_range(0, n + 2);
      for (i = 0; i < extra; i++) begin
         if (n == 0 || $urandom_range(0, 7) == 0)
            add_edge($urandom_range(0, 63), $urandom_range(0, 63));
         else
            add_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1));
      end
      add_compute();
   endtask

   // Main sequence
   initial begin
      int r;
      int cnt;
      int g;
      int graphs;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.kind         = vrfa_pkg::KIND_EDGE;
      req_bus.edge_from    = '0;
      req_bus.edge_to      = '0;
      rsp_bus.ready        = 1'b0;
      csr_bus.valid        = 1'b0;
      csr_bus.vertex_count = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Count at reset: extreme endpoints, a repeated link and a self loop
      add_edge(0, 63);
      add_edge(63, 0);
      add_edge(0, 63);
      add_edge(42, 42);
      add_compute();

      // Single vertex: empty graph, then a self loop and a stray link
      wait_drained();
      write_count(7'd1);
      add_compute();
      add_edge(0, 0);
      add_edge(63, 63);
      add_compute();

      // No vertex in use
      wait_drained();
      write_count(7'd0);
      add_edge(0, 1);
      add_compute();

      // Count above capacity saturates
      wait_drained();
      write_count(7'd127);
      add_edge(21, 42);
      add_compute();

      // Two vertices: a cycle, a one-way link, then a cleared graph
      wait_drained();
      write_count(7'd2);
      add_edge(0, 1);
      add_edge(1, 0);
      add_edge(1, 40);
      add_compute();
      add_edge(0, 1);
      add_compute();
      add_compute();

      // Hold the response side off while computes pile up behind it
      wait_drained();
      write_count(7'd4);
      hold_requests++;
      no_gaps = 1'b1;
      for (g = 0; g < 4; g++) queue_graph(4);
      wait_drained();
      no_gaps = 1'b0;

      // Random phases, each with its own vertex count
      while (items_queued < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 70) cnt = $urandom_range(2, 10);
         else if (r < 80) cnt = $urandom_range(11, 24);
         else if (r < 85) cnt = 1;
         else if (r < 88) cnt = 0;
         else if (r < 91) cnt = MAX_V;
         else if (r < 94) cnt = $urandom_range(MAX_V + 1, 127);
         else cnt = $urandom_range(25, MAX_V - 1);
         wait_drained();
         write_count(cnt[vrfa_pkg::COUNT_W-1:0]);
         if (cnt > MAX_V) cnt = MAX_V;
         no_gaps = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 19) == 0) hold_requests++;
         graphs = $urandom_range(1, 3);
         for (g = 0; g < graphs; g++) queue_graph(cnt);
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
